### rtl/mme_pkg.sv
// ----------------------------------------------------------------------------
// mme_pkg: shared definitions of the matrix multiply engine
// Field widths, command and register codes, sequencer-to-MAC control types.
// ----------------------------------------------------------------------------
`default_nettype none

package mme_pkg;

	// Default sizes of the element stores.
	localparam int MAX_DIM_DEF   = 8;
	localparam int ELEM_BITS_DEF = 16;

	// Fixed field widths of the streaming items.
	localparam int CMD_W   = 2;
	localparam int POS_W   = 3;
	localparam int VALUE_W = 16;
	localparam int SUM_W   = 35;
	localparam int REG_W   = 4;
	localparam int CFG_IDX_W = 2;

	// Input item commands; the fourth code is unused.
	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_A  = 2'd0,
		CMD_LOAD_B  = 2'd1,
		CMD_COMPUTE = 2'd2
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS_A = 2'd0,
		REG_INNER  = 2'd1,
		REG_COLS_B = 2'd2
	} reg_idx_t;

	// Control that travels with one multiply-accumulate step.
	typedef struct packed {
		logic             vld;
		logic             first;
		logic             last_k;
		logic             last;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} mac_ctl_t;

	// Finished result element held by the MAC unit.
	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             last;
		logic [SUM_W-1:0] sum;
	} mac_res_t;

	// Size register as used: zero counts as one, large values as the maximum.
	function automatic logic [REG_W-1:0] dim_clamp(input logic [REG_W-1:0] r,
			input logic [REG_W-1:0] max_dim);
		logic [REG_W-1:0] d;
		d = r;
		if (r == '0) begin
			d = REG_W'(1);
		end else if (r > max_dim) begin
			d = max_dim;
		end
		return d;
	endfunction

endpackage

`default_nettype wire

### rtl/mme_ram.sv
// ----------------------------------------------------------------------------
// mme_ram: element store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data in the cycle after the address.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### rtl/mme_mac.sv
// ----------------------------------------------------------------------------
// mme_mac: shared multiply-accumulate unit
// Multiplies one A and one B element per step and sums one dot product,
// then holds the finished element until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_mac
	import mme_pkg::*;
#(
	parameter int ELEM_BITS = ELEM_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire mac_ctl_t                    ctl,
	input  wire logic signed [ELEM_BITS-1:0] a_data,
	input  wire logic signed [ELEM_BITS-1:0] b_data,
	input  wire logic                        take,
	output logic                             done,
	output mac_res_t                         res
);

	localparam int PROD_W = 2 * ELEM_BITS;

	mac_ctl_t                  ctl_s2;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [SUM_W-1:0]   acc_q;
	logic                      done_q;
	logic [POS_W-1:0]          row_q;
	logic [POS_W-1:0]          col_q;
	logic                      last_q;

	// Multiply stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a_data * b_data;
	end

	// Accumulate stage; the sum wraps at the result width.
	always_ff @(posedge clk) begin
		if (ctl_s2.vld) begin
			if (ctl_s2.first) begin
				acc_q <= SUM_W'(prod_s2);
			end else begin
				acc_q <= acc_q + SUM_W'(prod_s2);
			end
		end
		if (ctl_s2.vld && ctl_s2.last_k) begin
			row_q  <= ctl_s2.row;
			col_q  <= ctl_s2.col;
			last_q <= ctl_s2.last;
		end
	end

	// Finished flag, set by the final step and cleared when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else if (ctl_s2.vld && ctl_s2.last_k) begin
			done_q <= 1'b1;
		end else if (take) begin
			done_q <= 1'b0;
		end
	end

	assign done     = done_q;
	assign res.row  = row_q;
	assign res.col  = col_q;
	assign res.last = last_q;
	assign res.sum  = acc_q;

endmodule

`default_nettype wire

### rtl/matrix_multiply_mac_engine_top.sv
// ----------------------------------------------------------------------------
// matrix_multiply_mac_engine_top: integer matrix multiply C = A x B
// Load items write elements of A or B; a compute item streams out all of C.
// ----------------------------------------------------------------------------
// Load item: accepted whenever idle, the next item may follow at once.
// Compute item: each result element is summed by the single shared
// multiply-accumulate unit from the store reads, one step per inner index; the
// next element starts only after the last one moved to the output register.
// Reset sets all three size registers to 1; the element stores are not
// cleared and hold unknown data until written. No clearing pass is run.
`default_nettype none

module matrix_multiply_mac_engine_top
	import mme_pkg::*;
#(
	parameter int MAX_DIM   = MAX_DIM_DEF,
	parameter int ELEM_BITS = ELEM_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration write port
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [REG_W-1:0]     cfg_data,
	// input items
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// row_index [2:0], col_index [5:3], element_value [21:6], zero [23:22]
	input  wire logic [23:0]          s_tdata,
	// command [1:0]
	input  wire logic [CMD_W-1:0]     s_tuser,
	// result items
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// out_row [2:0], out_col [5:3], product_sum [40:6], zero [47:41]
	output logic [47:0]               m_tdata,
	output logic                      m_tlast
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int IDX_W = $clog2(MAX_DIM);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_ISSUE = 3'b010,
		S_DRAIN = 3'b100
	} state_t;

	state_t                 state_q;
	logic [REG_W-1:0]       rows_a_q;
	logic [REG_W-1:0]       inner_q;
	logic [REG_W-1:0]       cols_b_q;
	logic [IDX_W-1:0]       i_q;
	logic [IDX_W-1:0]       j_q;
	logic [IDX_W-1:0]       k_q;
	logic [IDX_W-1:0]       i_end;
	logic [IDX_W-1:0]       j_end;
	logic [IDX_W-1:0]       k_end;
	logic                   elem_last;
	mac_ctl_t               issue_ctl;
	mac_ctl_t               ctl_s1;
	logic [AW-1:0]          raddr_a;
	logic [AW-1:0]          raddr_b;
	logic [AW-1:0]          waddr;
	logic                   in_acc;
	logic                   in_range;
	logic                   we_a;
	logic                   we_b;
	logic [POS_W-1:0]       in_row;
	logic [POS_W-1:0]       in_col;
	logic signed [VALUE_W-1:0]   in_value;
	logic signed [ELEM_BITS-1:0] wdata;
	logic [ELEM_BITS-1:0]   rdata_a;
	logic [ELEM_BITS-1:0]   rdata_b;
	logic                   mac_done;
	mac_res_t               mac_res;
	logic                   take;
	logic                   out_vld_q;
	mac_res_t               out_q;

	// Input item fields.
	assign in_row   = s_tdata[2:0];
	assign in_col   = s_tdata[5:3];
	assign in_value = s_tdata[21:6];
	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= REG_W'(1);
			inner_q  <= REG_W'(1);
			cols_b_q <= REG_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROWS_A: rows_a_q <= cfg_data;
				REG_INNER:  inner_q  <= cfg_data;
				REG_COLS_B: cols_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Last index of each loop after clamping the sizes.
	assign i_end = IDX_W'(dim_clamp(rows_a_q, REG_W'(MAX_DIM)) - REG_W'(1));
	assign k_end = IDX_W'(dim_clamp(inner_q, REG_W'(MAX_DIM)) - REG_W'(1));
	assign j_end = IDX_W'(dim_clamp(cols_b_q, REG_W'(MAX_DIM)) - REG_W'(1));
	assign elem_last = (i_q == i_end) && (j_q == j_end);

	// Element loads; an index past the store size is dropped.
	assign in_range = (REG_W'(in_row) < REG_W'(MAX_DIM)) &&
			(REG_W'(in_col) < REG_W'(MAX_DIM));
	assign waddr = AW'(in_row * MAX_DIM + in_col);
	assign wdata = ELEM_BITS'(in_value);
	assign we_a  = in_acc && in_range && (s_tuser == CMD_LOAD_A);
	assign we_b  = in_acc && in_range && (s_tuser == CMD_LOAD_B);

	// Store reads of the current step: A(i,k) and B(k,j).
	assign raddr_a = AW'(i_q * MAX_DIM + k_q);
	assign raddr_b = AW'(k_q * MAX_DIM + j_q);

	mme_ram #(.DEPTH(DEPTH), .WIDTH(ELEM_BITS)) u_store_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	mme_ram #(.DEPTH(DEPTH), .WIDTH(ELEM_BITS)) u_store_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	// Control of the step issued this cycle.
	always_comb begin
		issue_ctl        = '0;
		issue_ctl.vld    = (state_q == S_ISSUE);
		issue_ctl.first  = (k_q == '0);
		issue_ctl.last_k = (k_q == k_end);
		issue_ctl.last   = elem_last;
		issue_ctl.row    = POS_W'(i_q);
		issue_ctl.col    = POS_W'(j_q);
	end

	// Control delayed to line up with the store read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= issue_ctl;
		end
	end

	mme_mac #(.ELEM_BITS(ELEM_BITS)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_s1),
		.a_data (rdata_a),
		.b_data (rdata_b),
		.take   (take),
		.done   (mac_done),
		.res    (mac_res)
	);

	// A finished element moves to the output register once it is free.
	assign take = mac_done && (!out_vld_q || m_tready);

	// Sequencer over i, j and k.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc && (s_tuser == CMD_COMPUTE)) begin
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					if (k_q == k_end) begin
						k_q     <= '0;
						state_q <= S_DRAIN;
					end else begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				S_DRAIN: begin
					if (take) begin
						if (elem_last) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_ISSUE;
							if (j_q == j_end) begin
								j_q <= '0;
								i_q <= i_q + IDX_W'(1);
							end else begin
								j_q <= j_q + IDX_W'(1);
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (take) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= mac_res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {7'd0, out_q.sum, out_q.col, out_q.row};
	assign m_tlast  = out_q.last;

	// The next dot product never starts while a finished one waits in the MAC.
	a_issue_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ISSUE) |-> !mac_done)
		else $error("dot product issued while a finished element is pending");

	// A finished element only appears after all steps of it were issued.
	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(mac_done) |-> (state_q == S_DRAIN))
		else $error("finished element outside the drain phase");

	// When new items are taken the MAC pipeline is empty.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!mac_done && !ctl_s1.vld))
		else $error("ready while the MAC unit still holds work");

endmodule

`default_nettype wire

### tb/matrix_multiply_mac_engine_top_test.sv
// ----------------------------------------------------------------------------
// matrix_multiply_mac_engine_top_test: self-checking bench of the matrix engine
// Loads elements of A and B, starts products over many size settings and
// checks every element of C, with its row, column and last flag, against a
// product computed in the bench or typed into the table. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module matrix_multiply_mac_engine_top_test
	import mme_pkg::*;
();

	// Command code that the engine ignores.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// Cycles allowed for the engine to settle after the last result.
	localparam int SETTLE_CYCLES = 30;
	// Length of the long output stall that backs up the engine.
	localparam int LONG_HOLD_CYCLES = 300;

	// One element of C as it leaves the engine.
	typedef struct {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic [SUM_W-1:0] sum;
		logic             last;
	} c_elem_t;

	// Rows of the directed stimulus table.
	typedef enum {ROW_ITEM, ROW_SIZES} row_kind_t;

	typedef struct {
		row_kind_t                  kind;
		logic [CMD_W-1:0]           cmd;
		logic [POS_W-1:0]           row;
		logic [POS_W-1:0]           col;
		logic signed [VALUE_W-1:0]  value;
		bit                         typed;
		longint                     sum;
		logic [REG_W-1:0]           n_rows;
		logic [REG_W-1:0]           n_inner;
		logic [REG_W-1:0]           n_cols;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_ROWS_A;
	logic [REG_W-1:0]     cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [23:0]          s_tdata = '0;
	logic [CMD_W-1:0]     s_tuser = CMD_LOAD_A;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [47:0]          m_tdata;
	logic                 m_tlast;

	// Bench copy of the engine state.
	logic signed [VALUE_W-1:0] mat_a [MAX_DIM_DEF][MAX_DIM_DEF];
	logic signed [VALUE_W-1:0] mat_b [MAX_DIM_DEF][MAX_DIM_DEF];
	bit                        a_loaded [MAX_DIM_DEF][MAX_DIM_DEF];
	bit                        b_loaded [MAX_DIM_DEF][MAX_DIM_DEF];
	logic [REG_W-1:0]          size_rows = 4'd1;
	logic [REG_W-1:0]          size_inner = 4'd1;
	logic [REG_W-1:0]          size_cols = 4'd1;

	// Elements of C still to come, oldest first.
	c_elem_t pending_c [$];

	int  err_count = 0;
	int  rand_items = 0;
	int  c_predicted = 0;
	bit  idle_on = 1'b1;
	bit  hold_req = 1'b0;

	matrix_multiply_mac_engine_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit.
	initial begin
		#1000000;
		$display("FAIL");
		$finish;
	end

	// Size register as the engine uses it.
	function automatic int eff_dim(logic [REG_W-1:0] r);
		if (r == 0) return 1;
		if (r > MAX_DIM_DEF) return MAX_DIM_DEF;
		return int'(r);
	endfunction

	// Random element value, with the extremes drawn often.
	function automatic logic signed [VALUE_W-1:0] rand_elem();
		case ($urandom_range(0, 15))
			0: return {1'b1, {(VALUE_W-1){1'b0}}};
			1: return {1'b0, {(VALUE_W-1){1'b1}}};
			2: return '0;
			default: return VALUE_W'($urandom);
		endcase
	endfunction

	// Table rows.
	function automatic stim_row_t item_row(logic [CMD_W-1:0] cmd, int r, int c, int v);
		stim_row_t t;
		t.kind = ROW_ITEM;
		t.cmd = cmd;
		t.row = POS_W'(r);
		t.col = POS_W'(c);
		t.value = VALUE_W'(v);
		t.typed = 1'b0;
		t.sum = 0;
		t.n_rows = '0;
		t.n_inner = '0;
		t.n_cols = '0;
		return t;
	endfunction

	// Single-element product whose value is typed in.
	function automatic stim_row_t check_row(longint s);
		stim_row_t t;
		t = item_row(CMD_COMPUTE, 0, 0, 0);
		t.typed = 1'b1;
		t.sum = s;
		return t;
	endfunction

	function automatic stim_row_t sizes_row(int r, int i, int c);
		stim_row_t t;
		t = item_row(CMD_LOAD_A, 0, 0, 0);
		t.kind = ROW_SIZES;
		t.n_rows = REG_W'(r);
		t.n_inner = REG_W'(i);
		t.n_cols = REG_W'(c);
		return t;
	endfunction

	// Update the bench state with one accepted item and queue any elements of C.
	task automatic predict_c_elements(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] r,
			logic [POS_W-1:0] c, logic signed [VALUE_W-1:0] v);
		c_elem_t e;
		int      nr, ni, nc, i, j, k;
		longint  acc;
		if (cmd == CMD_LOAD_A) begin
			mat_a[r][c] = v;
			a_loaded[r][c] = 1'b1;
		end else if (cmd == CMD_LOAD_B) begin
			mat_b[r][c] = v;
			b_loaded[r][c] = 1'b1;
		end else if (cmd == CMD_COMPUTE) begin
			nr = eff_dim(size_rows);
			ni = eff_dim(size_inner);
			nc = eff_dim(size_cols);
			for (i = 0; i < nr; i++) begin
				for (j = 0; j < nc; j++) begin
					acc = 0;
					for (k = 0; k < ni; k++) begin
						acc += longint'(mat_a[i][k]) * longint'(mat_b[k][j]);
					end
					e.row = POS_W'(i);
					e.col = POS_W'(j);
					e.sum = acc[SUM_W-1:0];
					e.last = (i == nr - 1) && (j == nc - 1);
					pending_c.push_back(e);
					c_predicted++;
				end
			end
		end
	endtask

	// Offer one item and hold it until the engine takes it.
	task automatic send_item(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] r,
			logic [POS_W-1:0] c, logic signed [VALUE_W-1:0] v);
		int gap;
		gap = idle_on ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, v, c, r};
		s_tuser <= cmd;
		do @(posedge clk); while (!s_tready);
	endtask

	// Random-part item: send, predict, count.
	task automatic issue(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] r,
			logic [POS_W-1:0] c, logic signed [VALUE_W-1:0] v);
		send_item(cmd, r, c, v);
		predict_c_elements(cmd, r, c, v);
		if (cmd != CMD_UNUSED) rand_items++;
	endtask

	// Wait until every element of C has arrived and the engine has settled.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_c.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all three size registers; only called while the engine is idle.
	task automatic set_sizes(logic [REG_W-1:0] r, logic [REG_W-1:0] i,
			logic [REG_W-1:0] c);
		cfg_we <= 1'b1;
		cfg_index <= REG_ROWS_A;
		cfg_data <= r;
		@(posedge clk);
		cfg_index <= REG_INNER;
		cfg_data <= i;
		@(posedge clk);
		cfg_index <= REG_COLS_B;
		cfg_data <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		size_rows = r;
		size_inner = i;
		size_cols = c;
	endtask

	// Load every entry that the next product reads and that was never written.
	task automatic fill_missing();
		int nr, ni, nc, i, j;
		nr = eff_dim(size_rows);
		ni = eff_dim(size_inner);
		nc = eff_dim(size_cols);
		for (i = 0; i < nr; i++)
			for (j = 0; j < ni; j++)
				if (!a_loaded[i][j]) issue(CMD_LOAD_A, POS_W'(i), POS_W'(j), rand_elem());
		for (i = 0; i < ni; i++)
			for (j = 0; j < nc; j++)
				if (!b_loaded[i][j]) issue(CMD_LOAD_B, POS_W'(i), POS_W'(j), rand_elem());
	endtask

	// Mostly loads inside the active part of A and B, some anywhere, some ignored.
	task automatic random_item();
		int x, nr, ni, nc;
		nr = eff_dim(size_rows);
		ni = eff_dim(size_inner);
		nc = eff_dim(size_cols);
		x = $urandom_range(0, 19);
		if (x < 7)
			issue(CMD_LOAD_A, POS_W'($urandom_range(0, nr - 1)),
				POS_W'($urandom_range(0, ni - 1)), rand_elem());
		else if (x < 14)
			issue(CMD_LOAD_B, POS_W'($urandom_range(0, ni - 1)),
				POS_W'($urandom_range(0, nc - 1)), rand_elem());
		else if (x < 17)
			issue((x == 14) ? CMD_LOAD_A : CMD_LOAD_B, POS_W'($urandom_range(0, 7)),
				POS_W'($urandom_range(0, 7)), rand_elem());
		else
			issue(CMD_UNUSED, POS_W'($urandom_range(0, 7)),
				POS_W'($urandom_range(0, 7)), VALUE_W'($urandom));
	endtask

	// Size register value: mostly small, sometimes zero or at or past the maximum.
	function automatic logic [REG_W-1:0] pick_size();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return REG_W'($urandom_range(MAX_DIM_DEF, 15));
			default: return REG_W'($urandom_range(1, 3));
		endcase
	endfunction

	// One setting of the sizes followed by loads and one or more products.
	task automatic run_phase(logic [REG_W-1:0] r, logic [REG_W-1:0] i,
			logic [REG_W-1:0] c, bit burst);
		int n;
		wait_idle();
		set_sizes(r, i, c);
		idle_on = ($urandom_range(0, 3) != 0);
		n = $urandom_range(0, 8);
		repeat (n) random_item();
		if (burst) begin
			// Keep offering products while the output is held off.
			idle_on = 1'b0;
			hold_req = 1'b1;
			repeat (3) begin
				fill_missing();
				issue(CMD_COMPUTE, '0, '0, '0);
				repeat (4) random_item();
			end
		end else begin
			fill_missing();
			issue(CMD_COMPUTE, '0, '0, '0);
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(0, 3)) random_item();
				fill_missing();
				issue(CMD_COMPUTE, '0, '0, '0);
			end
		end
	endtask

	// Result side: random stalls, one long hold when asked, check every element.
	initial begin : c_sink
		int      gap;
		c_elem_t want;
		c_elem_t got;
		@(posedge arst_n);
		forever begin
			gap = hold_req ? LONG_HOLD_CYCLES : (idle_on ? $urandom_range(0, 8) : 0);
			hold_req = 1'b0;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got.row = m_tdata[2:0];
			got.col = m_tdata[5:3];
			got.sum = m_tdata[40:6];
			got.last = m_tlast;
			if (pending_c.size() == 0) begin
				err_count++;
				$display("%0t: unexpected result: row %0d col %0d sum %0d last %b",
					$time, got.row, got.col, $signed(got.sum), got.last);
			end else begin
				want = pending_c.pop_front();
				if (got.row !== want.row || got.col !== want.col ||
						got.sum !== want.sum || got.last !== want.last) begin
					err_count++;
					$display("%0t: mismatch: expected row %0d col %0d sum %0d last %b, got row %0d col %0d sum %0d last %b",
						$time, want.row, want.col, $signed(want.sum), want.last,
						got.row, got.col, $signed(got.sum), got.last);
				end
			end
		end
	end

	// Stimulus: directed table, then random phases, then the final check.
	initial begin : stimulus
		stim_row_t stim_table [$];
		stim_row_t t;
		c_elem_t   e;

		// Extremes of the element values on 1 x 1 x 1 products.
		stim_table.push_back(item_row(CMD_LOAD_A, 0, 0, -32768));
		stim_table.push_back(item_row(CMD_LOAD_B, 0, 0, -32768));
		stim_table.push_back(check_row(64'sd1073741824));
		stim_table.push_back(item_row(CMD_LOAD_A, 0, 0, 32767));
		stim_table.push_back(check_row(-64'sd1073709056));
		stim_table.push_back(item_row(CMD_LOAD_B, 0, 0, 32767));
		stim_table.push_back(check_row(64'sd1073676289));
		// The unused command must not touch the stores.
		stim_table.push_back(item_row(CMD_UNUSED, 0, 0, 1));
		stim_table.push_back(check_row(64'sd1073676289));
		// Highest indexes, outside the active sizes.
		stim_table.push_back(item_row(CMD_LOAD_A, 7, 7, -1));
		stim_table.push_back(item_row(CMD_LOAD_B, 7, 7, 1));
		// Size registers at zero act as one.
		stim_table.push_back(sizes_row(0, 0, 0));
		stim_table.push_back(check_row(64'sd1073676289));
		stim_table.push_back(item_row(CMD_LOAD_A, 0, 0, 0));
		stim_table.push_back(check_row(64'sd0));
		stim_table.push_back(item_row(CMD_LOAD_A, 0, 0, -1));
		stim_table.push_back(item_row(CMD_LOAD_B, 0, 0, -1));
		stim_table.push_back(check_row(64'sd1));
		// Small shapes checked by the bench product.
		stim_table.push_back(sizes_row(1, 2, 1));
		stim_table.push_back(item_row(CMD_LOAD_A, 0, 1, 100));
		stim_table.push_back(item_row(CMD_LOAD_B, 1, 0, -7));
		stim_table.push_back(item_row(CMD_COMPUTE, 0, 0, 0));
		stim_table.push_back(sizes_row(2, 1, 2));
		stim_table.push_back(item_row(CMD_LOAD_A, 1, 0, 12345));
		stim_table.push_back(item_row(CMD_LOAD_B, 0, 1, -23456));
		stim_table.push_back(item_row(CMD_COMPUTE, 0, 0, 0));

		// Reset.
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[n]) begin
			t = stim_table[n];
			if (t.kind == ROW_SIZES) begin
				wait_idle();
				set_sizes(t.n_rows, t.n_inner, t.n_cols);
			end else begin
				send_item(t.cmd, t.row, t.col, t.value);
				if (t.typed) begin
					e.row = '0;
					e.col = '0;
					e.sum = t.sum[SUM_W-1:0];
					e.last = 1'b1;
					pending_c.push_back(e);
				end else begin
					predict_c_elements(t.cmd, t.row, t.col, t.value);
				end
			end
		end

		// Random part; the first phase backs up the engine behind a long hold.
		run_phase(4'd3, 4'd3, 4'd3, 1'b1);
		while (rand_items < 60 || c_predicted < 60)
			run_phase(pick_size(), pick_size(), pick_size(), 1'b0);
		// Most result elements, with row and column sizes past the maximum.
		run_phase(4'd15, 4'd2, 4'd9, 1'b0);

		wait_idle();
		if (err_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
